FILE: design/bcc_pkg.sv
// shared types and constants of the button click classifier
package bcc_pkg;

   localparam int unsigned TICK_WIDTH  = 32;
   localparam int unsigned CFG_WIDTH   = 16;
   localparam int unsigned CFG_IDX_W   = 2;
   localparam int unsigned REQ_DATA_W  = 40;
   localparam int unsigned RSP_DATA_W  = 8;

   localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET = 16'd10;
   localparam logic [CFG_WIDTH-1:0] RELEASE_RESET  = 16'd500;
   localparam logic [CFG_WIDTH-1:0] LONG_RESET     = 16'd2000;

   typedef enum logic [CFG_IDX_W-1:0] {
      REG_DEBOUNCE = 2'd0,
      REG_RELEASE  = 2'd1,
      REG_LONG     = 2'd2
   } reg_index_type;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_PUSHED   = 3'd1,
      PH_RELEASED = 3'd2,
      PH_LONG     = 3'd3,
      PH_EXIT     = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_LONG   = 2'd1,
      EV_SINGLE = 2'd2,
      EV_DOUBLE = 2'd3
   } event_type;

endpackage

FILE: design/button_click_classifier.sv
// button click classifier: phase machine that sorts button samples into click events
// an accepted req transfer passes the input register, then the phase update and the
//    result register, before its rsp transfer
// throughput: one sample per cycle unless rsp_tready stalls; the phase update is a single
//    pass of three 32-bit window adds and compares against the sample's tick
// reset: synchronous, active high; clears the phase to idle, the press start tick, both
//    flags, the sticky event and all valid bits, and reloads the three window registers
module button_click_classifier (
   input  logic                            clock,
   input  logic                            reset,
   // request stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [bcc_pkg::REQ_DATA_W-1:0]  req_tdata,   // [0] pressed, [32:1] now_tick
   // result stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [bcc_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // [1:0] click_event, [4:2] phase_now
   // register writes
   input  logic                            csr_we,
   input  logic [bcc_pkg::CFG_IDX_W-1:0]   csr_index,
   input  logic [bcc_pkg::CFG_WIDTH-1:0]   csr_wdata
);
   import bcc_pkg::*;

   // window registers
   logic [CFG_WIDTH-1:0] debounce_ff;
   logic [CFG_WIDTH-1:0] release_ff;
   logic [CFG_WIDTH-1:0] long_ff;

   // input register stage
   logic                  in_valid_ff;
   logic                  pressed_ff;
   logic [TICK_WIDTH-1:0] now_ff;

   // classifier state
   phase_type             phase_ff, phase_in;
   logic [TICK_WIDTH-1:0] start_ff, start_in;
   logic                  held_ff, held_in;
   logic                  dbl_ff, dbl_in;
   event_type             event_ff, event_in;

   // result register
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   // handshake: the result register frees up when empty or taken this cycle
   logic advance;
   logic fire;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // register writes, out-of-range index ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
         release_ff  <= RELEASE_RESET;
         long_ff     <= LONG_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_DEBOUNCE: debounce_ff <= csr_wdata;
            REG_RELEASE:  release_ff  <= csr_wdata;
            REG_LONG:     long_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input stage, loads whenever it is empty or moving on
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         pressed_ff <= req_tdata[0];
         now_ff     <= req_tdata[TICK_WIDTH:1];
      end
   end

   // window ends wrap modulo 2^32, then an unsigned compare against the tick
   logic [TICK_WIDTH-1:0] debounce_end;
   logic [TICK_WIDTH-1:0] release_end;
   logic [TICK_WIDTH-1:0] long_end;
   logic                  debounce_wait;
   logic                  release_wait;
   logic                  long_reached;

   assign debounce_end  = start_ff + {{(TICK_WIDTH-CFG_WIDTH){1'b0}}, debounce_ff};
   assign release_end   = start_ff + {{(TICK_WIDTH-CFG_WIDTH){1'b0}}, release_ff};
   assign long_end      = start_ff + {{(TICK_WIDTH-CFG_WIDTH){1'b0}}, long_ff};
   assign debounce_wait = now_ff < debounce_end;
   assign release_wait  = now_ff < release_end;
   assign long_reached  = now_ff >= long_end;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            if (pressed_ff) phase_in = PH_PUSHED;
         end
         PH_PUSHED: begin
            if (!debounce_wait) begin
               if (pressed_ff) begin
                  if (long_reached) phase_in = PH_LONG;
               end else begin
                  // a glitch that was never seen held skips the release window
                  phase_in = held_ff ? PH_RELEASED : PH_EXIT;
               end
            end
         end
         PH_RELEASED: begin
            if (!release_wait && !pressed_ff) phase_in = PH_EXIT;
         end
         PH_LONG: begin
            if (!pressed_ff) phase_in = PH_EXIT;
         end
         PH_EXIT: phase_in = PH_IDLE;
         default: phase_in = phase_ff;
      endcase
   end

   // press start tick, flags and sticky event
   always_comb begin
      start_in = start_ff;
      held_in  = held_ff;
      dbl_in   = dbl_ff;
      event_in = event_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            if (pressed_ff) start_in = now_ff;
         end
         PH_PUSHED: begin
            if (!debounce_wait) begin
               if (pressed_ff) begin
                  if (long_reached) begin
                     event_in = EV_LONG;
                     held_in  = 1'b0;
                  end else begin
                     held_in  = 1'b1;
                  end
               end else begin
                  held_in = 1'b0;
               end
            end
         end
         PH_RELEASED: begin
            if (!release_wait) begin
               if (!pressed_ff) begin
                  if (!dbl_ff) event_in = EV_SINGLE;
                  dbl_in = 1'b0;
               end else if (!dbl_ff) begin
                  // a second press inside the phase counts once
                  dbl_in   = 1'b1;
                  event_in = EV_DOUBLE;
               end
            end
         end
         PH_LONG: begin
            if (pressed_ff) event_in = EV_LONG;
         end
         PH_EXIT: start_in = '0;
         default: ;
      endcase
   end

   // state update, one sample per transfer into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         start_ff <= '0;
         held_ff  <= 1'b0;
         dbl_ff   <= 1'b0;
         event_ff <= EV_NONE;
      end else if (fire) begin
         phase_ff <= phase_in;
         start_ff <= start_in;
         held_ff  <= held_in;
         dbl_ff   <= dbl_in;
         event_ff <= event_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= {3'b000, phase_in, event_in};
      end
   end

   // held flag only lives while the press is being measured
   a_held_in_pushed: assert property (@(posedge clock) disable iff (reset)
      held_ff |-> phase_ff == PH_PUSHED)
      else $error("held flag set outside pushed phase");

   // double mark only lives inside the release window phase
   a_dbl_in_released: assert property (@(posedge clock) disable iff (reset)
      dbl_ff |-> phase_ff == PH_RELEASED)
      else $error("double mark set outside released phase");

   // the event is sticky until reset
   a_event_sticky: assert property (@(posedge clock) disable iff (reset)
      event_ff != EV_NONE |=> event_ff != EV_NONE)
      else $error("sticky event was cleared");

   // state only moves with a sample transfer into the result register
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(phase_ff) && $stable(event_ff) && $stable(start_ff))
      else $error("state changed without a sample");

   // an empty result register never stalls the request side
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_tready)
      else $error("request stalled with empty result register");

endmodule

FILE: tb/sv/tb_button_click_classifier.sv
`timescale 1ns / 1ps
// self-checking testbench of the button click classifier: press gestures in, checked events out
module tb_button_click_classifier;
   import bcc_pkg::*;

   // cycles with no transfer of any kind and no register write before the run is declared hung
   localparam int unsigned QUIET_LIMIT = 3000;
   // random samples per register setting, eight settings in all
   localparam int unsigned SAMPLES_PER_SETTING = 56;

   // prediction of the phase machine plus the queue of results still owed by the block
   class click_scoreboard;
      typedef struct packed {
         event_type ev;
         phase_type ph;
      } click_result_type;

      logic [CFG_WIDTH-1:0]  debounce_win;
      logic [CFG_WIDTH-1:0]  release_win;
      logic [CFG_WIDTH-1:0]  long_win;
      phase_type             phase;
      logic [TICK_WIDTH-1:0] press_tick;
      bit                    held_seen;
      bit                    double_done;
      event_type             last_event;
      click_result_type      owed_q[$];
      int unsigned           errors;
      int unsigned           samples;
      int unsigned           checked;
      int unsigned           raised[4];

      function new();
         debounce_win = DEBOUNCE_RESET;
         release_win  = RELEASE_RESET;
         long_win     = LONG_RESET;
         phase        = PH_IDLE;
         press_tick   = '0;
         held_seen    = 1'b0;
         double_done  = 1'b0;
         last_event   = EV_NONE;
      endfunction

      function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_WIDTH-1:0] value);
         case (idx)
            REG_DEBOUNCE: debounce_win = value;
            REG_RELEASE:  release_win  = value;
            REG_LONG:     long_win     = value;
            default: ;  // unmapped index has no effect
         endcase
      endfunction

      function void raise_event(event_type e);
         last_event = e;
         raised[e]++;
      endfunction

      // one accepted sample: advance the phase machine and owe one result
      function void classify_sample(bit down, logic [TICK_WIDTH-1:0] now);
         logic [TICK_WIDTH-1:0] debounce_end;
         logic [TICK_WIDTH-1:0] window_end;
         logic [TICK_WIDTH-1:0] long_end;
         click_result_type      r;
         // window ends wrap modulo 2^32 before the unsigned compare
         debounce_end = press_tick + {16'd0, debounce_win};
         window_end   = press_tick + {16'd0, release_win};
         long_end     = press_tick + {16'd0, long_win};
         samples++;
         case (phase)
            PH_IDLE: begin
               if (down) begin
                  phase      = PH_PUSHED;
                  press_tick = now;
               end
            end
            PH_PUSHED: begin
               if (now >= debounce_end) begin
                  if (down) begin
                     held_seen = 1'b1;
                     if (now >= long_end) begin
                        phase     = PH_LONG;
                        held_seen = 1'b0;
                        raise_event(EV_LONG);
                     end
                  end else begin
                     // a release with no held sample is a glitch
                     phase     = held_seen ? PH_RELEASED : PH_EXIT;
                     held_seen = 1'b0;
                  end
               end
            end
            PH_RELEASED: begin
               if (now >= window_end) begin
                  if (!down) begin
                     if (!double_done) raise_event(EV_SINGLE);
                     double_done = 1'b0;
                     phase       = PH_EXIT;
                  end else if (!double_done) begin
                     double_done = 1'b1;
                     raise_event(EV_DOUBLE);
                  end
               end
            end
            PH_LONG: begin
               if (!down) phase = PH_EXIT;
               else raise_event(EV_LONG);
            end
            PH_EXIT: begin
               phase      = PH_IDLE;
               press_tick = '0;
            end
            default: ;
         endcase
         r.ev = last_event;
         r.ph = phase;
         owed_q.push_back(r);
      endfunction

      function void check_result(logic [RSP_DATA_W-1:0] data);
         click_result_type want;
         if (owed_q.size() == 0) begin
            $error("result transfer with no sample waiting: rsp_tdata %h", data);
            errors++;
            return;
         end
         want = owed_q.pop_front();
         checked++;
         if (data[1:0] !== want.ev) begin
            $error("click_event mismatch: expected %0d, got %0d", want.ev, data[1:0]);
            errors++;
         end
         if (data[4:2] !== want.ph) begin
            $error("phase_now mismatch: expected %0d, got %0d", want.ph, data[4:2]);
            errors++;
         end
      endfunction

      function int pending();
         return owed_q.size();
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // [0] pressed, [32:1] now_tick
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // [1:0] click_event, [4:2] phase_now
   logic                  csr_we     = 1'b0;
   logic [CFG_IDX_W-1:0]  csr_index  = '0;
   logic [CFG_WIDTH-1:0]  csr_wdata  = '0;

   click_scoreboard sb;
   int unsigned     send_idle_pct  = 0;
   int unsigned     recv_stall_pct = 0;
   int unsigned     quiet_cycles   = 0;
   int unsigned     settings_used  = 1;

   button_click_classifier u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // monitor: everything seen here is the pre-edge value, i.e. what the block sampled
   always @(posedge clock) begin
      if (!reset) begin
         // register writes land before any sample of the same edge
         if (csr_we) sb.write_reg(csr_index, csr_wdata);
         if (req_tvalid && req_tready) sb.classify_sample(req_tdata[0], req_tdata[32:1]);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
      end
   end

   // hang detection: any transfer or register write restarts the count
   always @(posedge clock) begin
      if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("tb: failure");
            $finish;
         end
      end
   end

   // present one sample after a random gap and hold it until the transfer
   task automatic send_sample(bit down, logic [TICK_WIDTH-1:0] now);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, now, down};
      do @(posedge clock); while (!req_tready);
   endtask

   // register writes only once the block owes nothing
   task automatic load_windows(logic [CFG_WIDTH-1:0] deb, logic [CFG_WIDTH-1:0] rel,
                               logic [CFG_WIDTH-1:0] lng);
      req_tvalid <= 1'b0;
      // wait for an edge so the monitor has logged the last sample transfer
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= REG_DEBOUNCE;
      csr_wdata <= deb;
      @(posedge clock);
      csr_index <= REG_RELEASE;
      csr_wdata <= rel;
      @(posedge clock);
      csr_index <= REG_LONG;
      csr_wdata <= lng;
      @(posedge clock);
      csr_we    <= 1'b0;
      settings_used++;
   endtask

   // button held and released in runs, ticks moving forward at a pace fitted to the windows,
   // with a few samples of pure noise
   task automatic press_gestures(int unsigned count, int unsigned step_max);
      logic [TICK_WIDTH-1:0] tick;
      bit                    level;
      int unsigned           run_left;
      int unsigned           roll;
      level    = 1'b0;
      run_left = 0;
      // start near the top of the tick range now and then so windows wrap
      if ($urandom_range(2) == 0) tick = 32'hFFFF_FFFF - $urandom_range(0, step_max * 6);
      else tick = $urandom;
      repeat (count) begin
         if (run_left == 0) begin
            level    = ~level;
            run_left = $urandom_range(1, 12);
         end
         roll = $urandom_range(99);
         if (roll < 3) begin
            tick  = $urandom;
            level = 1'($urandom_range(1));
         end else if (roll < 10) begin
            tick = tick + $urandom_range(0, step_max * 4);
         end else begin
            tick = tick + $urandom_range(0, step_max);
         end
         send_sample(level, tick);
         run_left--;
      end
   endtask

   initial begin
      logic [CFG_WIDTH-1:0] deb, rel, lng, top;
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed, reset windows 10 / 500 / 2000
      send_sample(1'b0, 32'd0);
      // press just below the wrap: both windows wrap and end at once, long press
      send_sample(1'b1, 32'hFFFF_FFFB);
      send_sample(1'b1, 32'hFFFF_FFFC);
      send_sample(1'b1, 32'hFFFF_FFFD);
      send_sample(1'b0, 32'hFFFF_FFFE);
      send_sample(1'b0, 32'hFFFF_FFFF);
      // click then a press after the release window: double click, no single after it
      send_sample(1'b1, 32'd100);
      send_sample(1'b1, 32'd105);
      send_sample(1'b1, 32'd110);
      send_sample(1'b0, 32'd120);
      send_sample(1'b0, 32'd300);
      send_sample(1'b1, 32'd600);
      send_sample(1'b1, 32'd601);
      send_sample(1'b0, 32'd602);
      send_sample(1'b0, 32'd603);
      // release seen before any held sample: glitch straight to exit
      send_sample(1'b1, 32'd1000);
      send_sample(1'b0, 32'd1010);
      send_sample(1'b0, 32'd1011);
      // plain single click
      send_sample(1'b1, 32'd2000);
      send_sample(1'b1, 32'd2010);
      send_sample(1'b0, 32'd2011);
      send_sample(1'b0, 32'd2500);
      send_sample(1'b0, 32'd2501);

      // random gestures over several window settings and idling patterns
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: begin deb = '0; rel = '0; lng = '0; end
            1: begin deb = '1; rel = '1; lng = '1; end
            6: begin
               deb = 16'($urandom);
               rel = 16'($urandom);
               lng = 16'($urandom);
            end
            7: begin deb = DEBOUNCE_RESET; rel = RELEASE_RESET; lng = LONG_RESET; end
            default: begin
               deb = 16'($urandom_range(0, 20));
               rel = 16'($urandom_range(0, 80));
               lng = 16'($urandom_range(0, 150));
            end
         endcase
         load_windows(deb, rel, lng);
         if (p == 2) begin
            // unmapped register index must change nothing
            csr_we    <= 1'b1;
            csr_index <= 2'd3;
            csr_wdata <= 16'($urandom);
            @(posedge clock);
            csr_we    <= 1'b0;
         end
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
            default: begin send_idle_pct = 25; recv_stall_pct = 25; end
         endcase
         top = deb;
         if (rel > top) top = rel;
         if (lng > top) top = lng;
         press_gestures(SAMPLES_PER_SETTING, top / 5 + 4);
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      // a spare result would surface within the pipeline depth
      repeat (6) @(posedge clock);

      $display("tb: %0d samples over %0d window settings, %0d results checked",
               sb.samples, settings_used, sb.checked);
      $display("tb: events raised: long %0d, single %0d, double %0d",
               sb.raised[EV_LONG], sb.raised[EV_SINGLE], sb.raised[EV_DOUBLE]);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

FILE: sim.f
design/bcc_pkg.sv
design/button_click_classifier.sv
tb/sv/tb_button_click_classifier.sv
